>>> hw/rtl/bpa_pkg.sv
// Binned profile accumulator: shared types, constants and codes.
// Used by bpa_ctrl, bpa_dp and binned_profile_accumulator_unit.
`default_nettype none

package bpa_pkg;

   localparam int DETECTOR_COUNT = 540;
   localparam int MAX_GROUPS     = 8;
   localparam int MAX_BINS       = 64;

   localparam logic [15:0] CHARGE_TOP = 16'd38400;

   localparam logic [6:0]  CHARGE_BINS_RESET   = 7'd50;
   localparam logic [6:0]  POSITION_BINS_RESET = 7'd10;
   localparam logic [6:0]  TIME_BINS_RESET     = 7'd24;
   localparam logic [14:0] HALF_RANGE_RESET    = 15'd6144;

   localparam int BIN_STEPS = 7;
   localparam int DIV_STEPS = 57;

   localparam logic [1:0] CMD_CHARGE   = 2'd0;
   localparam logic [1:0] CMD_HEIGHT   = 2'd1;
   localparam logic [1:0] CMD_RESPONSE = 2'd2;

   localparam logic [1:0] ST_FILLED       = 2'd0;
   localparam logic [1:0] ST_OUT_OF_RANGE = 2'd1;
   localparam logic [1:0] ST_BAD_TARGET   = 2'd2;
   localparam logic [1:0] ST_SATURATED    = 2'd3;

   localparam logic [1:0] REG_CHARGE_BINS   = 2'd0;
   localparam logic [1:0] REG_POSITION_BINS = 2'd1;
   localparam logic [1:0] REG_TIME_BINS     = 2'd2;
   localparam logic [1:0] REG_HALF_RANGE    = 2'd3;

   typedef struct packed {
      logic [1:0]         command;
      logic [9:0]         detector;
      logic [2:0]         group_index;
      logic [5:0]         time_sample;
      logic [15:0]        charge;
      logic signed [15:0] position;
      logic signed [23:0] sample;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [5:0]         bin_index;
      logic [31:0]        entry_count;
      logic signed [23:0] bin_mean;
      logic [47:0]        bin_mean_square;
   } rsp_type;

   typedef struct packed {
      logic clr;
      logic capture;
      logic bin_step;
      logic check;
      logic read;
      logic mul;
      logic prep;
      logic div_step;
      logic finish;
      logic reject;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic range_ok;
      logic target_ok;
      logic saturated;
      logic is_charge;
   } stat_type;

endpackage

`default_nettype wire

>>> hw/rtl/bpa_dp.sv
// Binned profile accumulator datapath: config registers, bin divider, stores,
// running mean and mean-square dividers, response register. Uses bpa_pkg.
`default_nettype none

module bpa_dp #(
   parameter int DETECTOR_COUNT = bpa_pkg::DETECTOR_COUNT,
   parameter int MAX_GROUPS     = bpa_pkg::MAX_GROUPS,
   parameter int MAX_BINS       = bpa_pkg::MAX_BINS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire bpa_pkg::req_type req_data,
   input  wire logic             csr_write,
   input  wire logic [1:0]       csr_index,
   input  wire logic [14:0]      csr_data,
   input  wire bpa_pkg::cmd_type cmd,
   output bpa_pkg::stat_type     stat,
   output bpa_pkg::rsp_type      rsp_data
);

   localparam int DEPTH  = DETECTOR_COUNT * MAX_GROUPS * MAX_BINS;
   localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;

   typedef struct packed {
      logic [31:0]        count;
      logic signed [23:0] mean;
      logic [47:0]        msq;
   } row_type;

   logic [6:0]  charge_bins_ff, position_bins_ff, time_bins_ff;
   logic [14:0] half_range_ff;

   bpa_pkg::req_type req_ff;
   logic             range_ok_ff;
   logic [22:0]      brem_ff;
   logic [21:0]      bden_ff;
   logic [6:0]       bin_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [ADDR_W-1:0] clr_addr_ff;

   logic [31:0] charge_rd_ff;
   row_type     height_rd_ff, response_rd_ff;

   logic signed [56:0] prod_ff;
   logic [47:0]        y2_ff;
   logic               neg_ff, ge_ff;
   logic [56:0]        num_m_ff, num_s_ff;
   logic [32:0]        rem_m_ff, rem_s_ff;
   logic [32:0]        ne_ff;

   bpa_pkg::rsp_type rsp_ff;

   logic [31:0] charge_mem [DEPTH];
   row_type     height_mem [DEPTH];
   row_type     response_mem [DEPTH];

   function automatic logic [6:0] eff_bins(input logic [6:0] n);
      if ({2'b00, n} > 9'(MAX_BINS)) begin
         return 7'(MAX_BINS);
      end
      return n;
   endfunction

   // request decode
   logic [6:0]         n_c, n_p, n_t;
   logic signed [16:0] pos_s, h_s, shifted;
   logic               range_ok;
   logic [22:0]        bnum;
   logic [15:0]        bden;

   always_comb begin
      n_c      = eff_bins(charge_bins_ff);
      n_p      = eff_bins(position_bins_ff);
      n_t      = eff_bins(time_bins_ff);
      pos_s    = {req_data.position[15], req_data.position};
      h_s      = $signed({2'b00, half_range_ff});
      shifted  = pos_s + h_s;
      range_ok = 1'b0;
      bnum     = '0;
      bden     = 16'd1;
      case (req_data.command)
         bpa_pkg::CMD_CHARGE: begin
            range_ok = (n_c != 7'd0) && (req_data.charge < bpa_pkg::CHARGE_TOP);
            bnum     = 23'(n_c * req_data.charge);
            bden     = bpa_pkg::CHARGE_TOP;
         end
         bpa_pkg::CMD_HEIGHT: begin
            range_ok = {1'b0, req_data.time_sample} < n_t;
            bnum     = 23'(req_data.time_sample);
         end
         bpa_pkg::CMD_RESPONSE: begin
            range_ok = (n_p != 7'd0) && (half_range_ff != 15'd0)
                       && (pos_s >= -h_s) && (pos_s < h_s);
            bnum     = 23'(n_p * shifted[15:0]);
            bden     = {half_range_ff, 1'b0};
         end
         default: begin
            range_ok = 1'b0;
         end
      endcase
   end

   // slot selection
   logic        target_ok;
   logic [31:0] slot;
   logic        is_charge;

   always_comb begin
      target_ok = ({1'b0, req_ff.detector} < 11'(DETECTOR_COUNT))
                  && ({4'b0, req_ff.group_index} < 7'(MAX_GROUPS));
      slot = (32'(req_ff.detector) * 32'(MAX_GROUPS) + 32'(req_ff.group_index))
             * 32'(MAX_BINS) + 32'(bin_ff);
      is_charge = req_ff.command == bpa_pkg::CMD_CHARGE;
   end

   // current row
   row_type     row;
   logic [31:0] cur_count, new_count;

   always_comb begin
      row       = (req_ff.command == bpa_pkg::CMD_HEIGHT) ? height_rd_ff : response_rd_ff;
      cur_count = is_charge ? charge_rd_ff : row.count;
      new_count = cur_count + 32'd1;
   end

   // prep and divider steps
   logic signed [56:0] num;
   logic [33:0]        tm, ts;
   logic [23:0]        new_mean;
   logic [47:0]        new_msq;

   always_comb begin
      num      = prod_ff + 57'(req_ff.sample);
      tm       = {rem_m_ff, num_m_ff[56]};
      ts       = {rem_s_ff, num_s_ff[56]};
      new_mean = neg_ff ? (24'd0 - num_m_ff[23:0]) : num_m_ff[23:0];
      new_msq  = ge_ff ? (row.msq + num_s_ff[47:0])
                       : (row.msq - (num_s_ff[47:0] + 48'(rem_s_ff != 33'd0)));
   end

   always_comb begin
      stat.clr_last  = clr_addr_ff == ADDR_W'(DEPTH - 1);
      stat.range_ok  = range_ok_ff;
      stat.target_ok = target_ok;
      stat.saturated = cur_count == 32'hFFFF_FFFF;
      stat.is_charge = is_charge;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         charge_bins_ff   <= bpa_pkg::CHARGE_BINS_RESET;
         position_bins_ff <= bpa_pkg::POSITION_BINS_RESET;
         time_bins_ff     <= bpa_pkg::TIME_BINS_RESET;
         half_range_ff    <= bpa_pkg::HALF_RANGE_RESET;
         clr_addr_ff      <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               bpa_pkg::REG_CHARGE_BINS:   charge_bins_ff   <= csr_data[6:0];
               bpa_pkg::REG_POSITION_BINS: position_bins_ff <= csr_data[6:0];
               bpa_pkg::REG_TIME_BINS:     time_bins_ff     <= csr_data[6:0];
               bpa_pkg::REG_HALF_RANGE:    half_range_ff    <= csr_data;
               default: begin
               end
            endcase
         end
         if (cmd.clr) begin
            clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff      <= req_data;
         range_ok_ff <= range_ok;
         brem_ff     <= bnum;
         bden_ff     <= {bden, 6'b0};
         bin_ff      <= '0;
      end
      if (cmd.bin_step) begin
         if (brem_ff >= {1'b0, bden_ff}) begin
            brem_ff <= brem_ff - {1'b0, bden_ff};
            bin_ff  <= {bin_ff[5:0], 1'b1};
         end else begin
            bin_ff  <= {bin_ff[5:0], 1'b0};
         end
         bden_ff <= bden_ff >> 1;
      end
      if (cmd.check) begin
         addr_ff <= slot[ADDR_W-1:0];
      end
      if (cmd.mul) begin
         prod_ff <= row.mean * $signed({1'b0, row.count});
         y2_ff   <= 48'(req_ff.sample * req_ff.sample);
      end
      if (cmd.prep) begin
         neg_ff   <= num[56];
         num_m_ff <= num[56] ? 57'(-num) : 57'(num);
         ge_ff    <= y2_ff >= row.msq;
         num_s_ff <= 57'((y2_ff >= row.msq) ? (y2_ff - row.msq) : (row.msq - y2_ff));
         ne_ff    <= {1'b0, row.count} + 33'd1;
         rem_m_ff <= '0;
         rem_s_ff <= '0;
      end
      if (cmd.div_step) begin
         if (tm >= {1'b0, ne_ff}) begin
            rem_m_ff <= 33'(tm - {1'b0, ne_ff});
            num_m_ff <= {num_m_ff[55:0], 1'b1};
         end else begin
            rem_m_ff <= tm[32:0];
            num_m_ff <= {num_m_ff[55:0], 1'b0};
         end
         if (ts >= {1'b0, ne_ff}) begin
            rem_s_ff <= 33'(ts - {1'b0, ne_ff});
            num_s_ff <= {num_s_ff[55:0], 1'b1};
         end else begin
            rem_s_ff <= ts[32:0];
            num_s_ff <= {num_s_ff[55:0], 1'b0};
         end
      end
      if (cmd.finish) begin
         rsp_ff.status          <= bpa_pkg::ST_FILLED;
         rsp_ff.bin_index       <= bin_ff[5:0];
         rsp_ff.entry_count     <= new_count;
         rsp_ff.bin_mean        <= is_charge ? 24'd0 : new_mean;
         rsp_ff.bin_mean_square <= is_charge ? 48'd0 : new_msq;
      end else if (cmd.reject) begin
         rsp_ff.status          <= !range_ok_ff ? bpa_pkg::ST_OUT_OF_RANGE :
                                   !target_ok   ? bpa_pkg::ST_BAD_TARGET :
                                                  bpa_pkg::ST_SATURATED;
         rsp_ff.bin_index       <= '0;
         rsp_ff.entry_count     <= '0;
         rsp_ff.bin_mean        <= '0;
         rsp_ff.bin_mean_square <= '0;
      end
   end

   // stores
   logic        wr_fill;
   row_type     new_row;
   logic [ADDR_W-1:0] waddr;

   always_comb begin
      wr_fill       = cmd.finish;
      waddr         = cmd.clr ? clr_addr_ff : addr_ff;
      new_row.count = new_count;
      new_row.mean  = new_mean;
      new_row.msq   = new_msq;
   end

   always_ff @(posedge clock) begin
      if (cmd.clr || (wr_fill && is_charge)) begin
         charge_mem[waddr] <= cmd.clr ? 32'd0 : new_count;
      end
      if (cmd.read) begin
         charge_rd_ff <= charge_mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr || (wr_fill && req_ff.command == bpa_pkg::CMD_HEIGHT)) begin
         height_mem[waddr] <= cmd.clr ? '0 : new_row;
      end
      if (cmd.read) begin
         height_rd_ff <= height_mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr || (wr_fill && req_ff.command == bpa_pkg::CMD_RESPONSE)) begin
         response_mem[waddr] <= cmd.clr ? '0 : new_row;
      end
      if (cmd.read) begin
         response_rd_ff <= response_mem[addr_ff];
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

>>> hw/rtl/bpa_ctrl.sv
// Binned profile accumulator controller: sequences clear pass, bin search,
// store access, divider steps and response handoff. Uses bpa_pkg.
`default_nettype none

module bpa_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire bpa_pkg::stat_type stat,
   output bpa_pkg::cmd_type       cmd
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_BIN, S_CHECK, S_READ, S_EVAL,
      S_MUL, S_PREP, S_DIV, S_FINISH, S_REJECT
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   always_comb begin
      slot_free    = !rsp_valid_ff || rsp_ready;
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               step_in     = '0;
               state_in    = S_BIN;
            end
         end
         S_BIN: begin
            cmd.bin_step = 1'b1;
            step_in      = step_ff + 6'd1;
            if (step_ff == 6'(bpa_pkg::BIN_STEPS - 1)) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = (stat.range_ok && stat.target_ok) ? S_READ : S_REJECT;
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (stat.saturated) begin
               state_in = S_REJECT;
            end else if (stat.is_charge) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_PREP;
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 6'd1;
            if (step_ff == 6'(bpa_pkg::DIV_STEPS - 1)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_REJECT: begin
            if (slot_free) begin
               cmd.reject   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !rsp_valid_ff)
      else $error("response during clear pass");

   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish || cmd.reject) |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> step_ff <= 6'(bpa_pkg::DIV_STEPS - 1))
      else $error("divider step count overrun");

   a_clear_alone: assert property (@(posedge clock) disable iff (reset)
      cmd.clr |-> !(cmd.finish || cmd.capture))
      else $error("store write during clear pass");

endmodule

`default_nettype wire

>>> hw/rtl/binned_profile_accumulator_unit.sv
// Binned profile accumulator top level: controller plus datapath.
// Depends on bpa_pkg, bpa_ctrl and bpa_dp.
//
// Usage: a request on req_* carries one fill (charge count, pulse-height fill
// or response fill) for one detector and group; exactly one response comes
// back on rsp_* per request, in order. Both channels are valid/ready. Bin
// counts and the position half range are written through csr_write,
// csr_index and csr_data while the unit is idle.
// Each request runs a bin search in a shared restoring divider. Requests out
// of range or with a bad detector or group are then rejected; other requests
// get a store read, after which charge counts and saturated counts respond,
// while pulse-height and response fills first run 57-step radix-2 dividers
// for mean and mean square.
// One request is in flight at a time; req_ready rises again in the cycle after
// the response is loaded.
// Reset: the stores are swept to zero one slot per cycle, over all
// DETECTOR_COUNT * MAX_GROUPS * MAX_BINS slots (276480 by default), and no
// request is taken until the sweep ends; register writes are taken throughout.
// Stall: the response register holds the result while rsp_ready is low; the
// next request may be taken and worked on meanwhile, and it waits to finish.
`default_nettype none

module binned_profile_accumulator_unit #(
   parameter int DETECTOR_COUNT = bpa_pkg::DETECTOR_COUNT,
   parameter int MAX_GROUPS     = bpa_pkg::MAX_GROUPS,
   parameter int MAX_BINS       = bpa_pkg::MAX_BINS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire bpa_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output bpa_pkg::rsp_type      rsp_data,
   input  wire logic             csr_write,
   input  wire logic [1:0]       csr_index,
   input  wire logic [14:0]      csr_data
);

   bpa_pkg::cmd_type  cmd;
   bpa_pkg::stat_type stat;

   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bpa_dp #(
      .DETECTOR_COUNT (DETECTOR_COUNT),
      .MAX_GROUPS     (MAX_GROUPS),
      .MAX_BINS       (MAX_BINS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> tb/tb.sv
// Testbench for binned_profile_accumulator_unit: directed table then random fills,
// every response checked against typed rows or fill predictor. Depends on bpa_pkg.
`timescale 1ns / 100ps

module tb;
   import bpa_pkg::*;

   localparam longint SLOT_COUNT = DETECTOR_COUNT * MAX_GROUPS * MAX_BINS;
   localparam int STALL_LIMIT = 1200000;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_write;
   logic [1:0]  csr_index;
   logic [14:0] csr_data;

   int unsigned charge_bins, position_bins, time_bins, half_range;
   int unsigned     bin_counts[longint];
   longint          bin_means[longint];
   longint unsigned bin_squares[longint];
   rsp_type         pending_rsp[$];
   int  fail_count;
   int  idle_cycles;
   bit  steady;
   bit  typed_next;
   rsp_type typed_rsp;

   binned_profile_accumulator_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned clamp_bins(int unsigned n);
      return n > MAX_BINS ? MAX_BINS : n;
   endfunction

   function automatic rsp_type fill_predict(req_type r);
      rsp_type         o;
      int unsigned     n;
      longint unsigned bin, e, ne, y2, sq;
      longint          h, p, y, nm, key;
      bit              ok;
      o = '0;
      ok = 1'b0;
      bin = 0;
      h = half_range;
      p = r.position;
      y = r.sample;
      case (r.command)
         CMD_CHARGE: begin
            n = clamp_bins(charge_bins);
            if (n != 0 && r.charge < CHARGE_TOP) begin
               bin = (longint'(n) * r.charge) / CHARGE_TOP;
               ok = 1'b1;
            end
         end
         CMD_HEIGHT: begin
            n = clamp_bins(time_bins);
            if (r.time_sample < n) begin
               bin = r.time_sample;
               ok = 1'b1;
            end
         end
         CMD_RESPONSE: begin
            n = clamp_bins(position_bins);
            if (n != 0 && h > 0 && p >= -h && p < h) begin
               bin = (longint'(n) * longint'(p + h)) / longint'(2 * h);
               ok = 1'b1;
            end
         end
         default: ok = 1'b0;
      endcase
      if (!ok) begin
         o.status = ST_OUT_OF_RANGE;
         return o;
      end
      if (r.detector >= DETECTOR_COUNT || r.group_index >= MAX_GROUPS) begin
         o.status = ST_BAD_TARGET;
         return o;
      end
      key = r.command * SLOT_COUNT
            + (longint'(r.detector) * MAX_GROUPS + r.group_index) * MAX_BINS + bin;
      e = bin_counts.exists(key) ? bin_counts[key] : 0;
      if (e == 64'hFFFF_FFFF) begin
         o.status = ST_SATURATED;
         return o;
      end
      ne = e + 1;
      if (r.command != CMD_CHARGE) begin
         nm = bin_means.exists(key) ? bin_means[key] : 0;
         sq = bin_squares.exists(key) ? bin_squares[key] : 0;
         nm = (nm * longint'(e) + y) / longint'(ne);
         y2 = y * y;
         if (y2 >= sq) sq = sq + (y2 - sq) / ne;
         else sq = sq - ((sq - y2) + ne - 1) / ne;
         bin_means[key] = nm;
         bin_squares[key] = sq;
         o.bin_mean = nm[23:0];
         o.bin_mean_square = sq[47:0];
      end
      bin_counts[key] = ne;
      o.status = ST_FILLED;
      o.bin_index = bin[5:0];
      o.entry_count = ne[31:0];
      return o;
   endfunction

   function automatic req_type make_req(logic [1:0] c, int d, int g, int t,
                                        int q, int p, int s);
      req_type r;
      r.command = c;
      r.detector = d;
      r.group_index = g;
      r.time_sample = t;
      r.charge = q;
      r.position = p;
      r.sample = s;
      return r;
   endfunction

   function automatic rsp_type reject_rsp(logic [1:0] st);
      rsp_type o;
      o = '0;
      o.status = st;
      return o;
   endfunction

   function automatic req_type random_req();
      req_type     r;
      int unsigned k;
      r = '0;
      k = $urandom_range(99);
      r.command = k < 5 ? 2'd3 : k < 35 ? CMD_CHARGE : k < 68 ? CMD_HEIGHT : CMD_RESPONSE;
      k = $urandom_range(99);
      r.detector = k < 70 ? $urandom_range(3) : k < 90 ? $urandom_range(539)
                 : $urandom_range(1023, 540);
      r.group_index = $urandom_range(99) < 70 ? $urandom_range(1) : $urandom_range(7);
      r.time_sample = $urandom_range(99) < 80 && time_bins != 0
                    ? $urandom_range(clamp_bins(time_bins) - 1) : $urandom_range(63);
      r.charge = $urandom_range(99) < 80 ? $urandom_range(38399) : $urandom_range(65535);
      r.position = $urandom_range(99) < 80 && half_range != 0
                 ? int'($urandom_range(2 * half_range - 1)) - int'(half_range)
                 : $urandom_range(65535);
      r.sample = $urandom;
      return r;
   endfunction

   task automatic send_request(req_type r);
      if (!steady) begin
         while ($urandom_range(99) < 16) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (typed_next) begin
         void'(fill_predict(r));
         pending_rsp.push_back(typed_rsp);
      end else begin
         pending_rsp.push_back(fill_predict(r));
      end
   endtask

   task automatic write_reg(logic [1:0] idx, int unsigned value);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         REG_CHARGE_BINS:   charge_bins = value & 7'h7F;
         REG_POSITION_BINS: position_bins = value & 7'h7F;
         REG_TIME_BINS:     time_bins = value & 7'h7F;
         default:           half_range = value & 15'h7FFF;
      endcase
   endtask

   task automatic set_config(int unsigned cb, int unsigned pb, int unsigned tb_n,
                             int unsigned hr);
      write_reg(REG_CHARGE_BINS, cb);
      write_reg(REG_POSITION_BINS, pb);
      write_reg(REG_TIME_BINS, tb_n);
      write_reg(REG_HALF_RANGE, hr);
   endtask

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) send_request(random_req());
   endtask

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= steady ? 1'b1 : ($urandom_range(99) >= 16);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("response with nothing expected: %p", rsp_data);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.bin_index !== want.bin_index) begin
               $error("bin_index: expected %0d, got %0d", want.bin_index,
                      rsp_data.bin_index);
               fail_count++;
            end
            if (rsp_data.entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, got %0d", want.entry_count,
                      rsp_data.entry_count);
               fail_count++;
            end
            if (rsp_data.bin_mean !== want.bin_mean) begin
               $error("bin_mean: expected %0d, got %0d", want.bin_mean, rsp_data.bin_mean);
               fail_count++;
            end
            if (rsp_data.bin_mean_square !== want.bin_mean_square) begin
               $error("bin_mean_square: expected %0d, got %0d", want.bin_mean_square,
                      rsp_data.bin_mean_square);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("binned_profile_accumulator_unit regression: fail");
         $finish;
      end
   end

   initial begin
      stim_row_type rows[$];
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_index = REG_CHARGE_BINS;
      csr_data = '0;
      fail_count = 0;
      idle_cycles = 0;
      steady = 1'b0;
      typed_next = 1'b0;
      typed_rsp = '0;
      charge_bins = CHARGE_BINS_RESET;
      position_bins = POSITION_BINS_RESET;
      time_bins = TIME_BINS_RESET;
      half_range = HALF_RANGE_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      rows.push_back('{make_req(CMD_CHARGE, 0, 0, 0, 0, 0, 0), 1,
                       '{ST_FILLED, 6'd0, 32'd1, 24'sd0, 48'd0}});
      rows.push_back('{make_req(CMD_CHARGE, 0, 0, 0, 38399, 0, 0), 0, '0});
      rows.push_back('{make_req(CMD_CHARGE, 0, 0, 0, 38400, 0, 0), 1,
                       reject_rsp(ST_OUT_OF_RANGE)});
      rows.push_back('{make_req(CMD_CHARGE, 0, 0, 0, 65535, 0, 0), 1,
                       reject_rsp(ST_OUT_OF_RANGE)});
      rows.push_back('{make_req(CMD_HEIGHT, 539, 7, 0, 0, 0, 8388607), 1,
                       '{ST_FILLED, 6'd0, 32'd1, 24'sd8388607, 48'd70368727400449}});
      rows.push_back('{make_req(CMD_HEIGHT, 539, 7, 0, 0, 0, -8388608), 0, '0});
      rows.push_back('{make_req(CMD_HEIGHT, 539, 7, 0, 65535, -1, -8388608), 0, '0});
      rows.push_back('{make_req(CMD_HEIGHT, 1, 3, 23, 0, 0, 4096), 0, '0});
      rows.push_back('{make_req(CMD_HEIGHT, 1, 3, 24, 0, 0, 4096), 1,
                       reject_rsp(ST_OUT_OF_RANGE)});
      rows.push_back('{make_req(CMD_HEIGHT, 1, 3, 63, 0, 0, 4096), 1,
                       reject_rsp(ST_OUT_OF_RANGE)});
      rows.push_back('{make_req(CMD_RESPONSE, 2, 1, 0, 0, -6144, -1), 0, '0});
      rows.push_back('{make_req(CMD_RESPONSE, 2, 1, 0, 0, 6143, 1), 0, '0});
      rows.push_back('{make_req(CMD_RESPONSE, 2, 1, 0, 0, 6144, 1), 1,
                       reject_rsp(ST_OUT_OF_RANGE)});
      rows.push_back('{make_req(CMD_RESPONSE, 2, 1, 0, 0, -6145, 1), 1,
                       reject_rsp(ST_OUT_OF_RANGE)});
      rows.push_back('{make_req(CMD_RESPONSE, 2, 1, 63, 65535, -32768, 0), 1,
                       reject_rsp(ST_OUT_OF_RANGE)});
      rows.push_back('{make_req(CMD_RESPONSE, 2, 1, 0, 0, 0, -5), 0, '0});
      rows.push_back('{make_req(CMD_RESPONSE, 2, 1, 0, 0, 0, 2), 0, '0});
      rows.push_back('{make_req(CMD_CHARGE, 540, 0, 0, 100, 0, 0), 1,
                       reject_rsp(ST_BAD_TARGET)});
      rows.push_back('{make_req(CMD_HEIGHT, 1023, 7, 0, 0, 0, 0), 1,
                       reject_rsp(ST_BAD_TARGET)});
      rows.push_back('{make_req(CMD_RESPONSE, 1023, 0, 0, 0, 32767, 0), 1,
                       reject_rsp(ST_OUT_OF_RANGE)});
      rows.push_back('{make_req(2'd3, 0, 0, 0, 0, 0, 0), 1, reject_rsp(ST_OUT_OF_RANGE)});
      rows.push_back('{make_req(2'd3, 1023, 7, 63, 65535, -1, -1), 1,
                       reject_rsp(ST_OUT_OF_RANGE)});

      set_config(CHARGE_BINS_RESET, POSITION_BINS_RESET, TIME_BINS_RESET,
                 HALF_RANGE_RESET);
      foreach (rows[i]) begin
         typed_next = rows[i].typed;
         typed_rsp = rows[i].rsp;
         send_request(rows[i].req);
      end
      typed_next = 1'b0;

      random_phase(250);
      set_config(1, 1, 1, 1);
      random_phase(150);
      set_config(64, 64, 64, 32767);
      steady = 1'b1;
      random_phase(200);
      steady = 1'b0;
      set_config(127, 127, 127, 4096);
      random_phase(200);
      set_config(0, 0, 0, 0);
      random_phase(100);
      set_config(3, 5, 8, 64);
      random_phase(300);
      set_config(50, 10, 24, 6144);
      random_phase(400);

      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending_rsp.size() == 0)
         $display("binned_profile_accumulator_unit regression: pass");
      else
         $display("binned_profile_accumulator_unit regression: fail");
      $finish;
   end
endmodule
